FILE: rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

  // Fixed widths of the port fields
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned COUNT_W = 32;

  // Frames in use after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Scan control from the sequencer
  typedef struct packed {
    logic start;   // clear the captured flags for a new transaction
    logic check;   // RAM read data is valid for the checked frame
  } scan_ctl_t;

  // Flags captured by the scan
  typedef struct packed {
    logic found;   // page is resident
    logic free_v;  // at least one free frame seen
  } scan_res_t;

  // Recency update command to the frame lanes
  typedef struct packed {
    logic en;      // apply the update this cycle
    logic hit;     // age only ranks below the bound; otherwise age all
  } lane_upd_t;

endpackage

FILE: rtl/lrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lrupr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/lrupr_lanes.sv
// Per-frame valid bits and recency ranks with a parallel aging update.
`timescale 1ns / 1ps

module lrupr_lanes #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned IW         = 4,
  parameter int unsigned RW         = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lrupr_pkg::lane_upd_t    upd_i,
  input  logic [IW-1:0]           slot_i,
  input  logic [RW-1:0]           bound_i,
  input  logic [IW-1:0]           rd_idx_i,
  output logic                    rd_valid_o,
  output logic [RW-1:0]           rd_rank_o,
  output logic [MAX_FRAMES-1:0]   valid_o
);

  logic [MAX_FRAMES-1:0] valid_q;
  logic [RW-1:0]         rank_q [MAX_FRAMES];

  // Update every lane at once: install the slot as most recent, age the rest (on a hit only those below the bound)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        rank_q[j] <= '0;
      end
    end else if (upd_i.en) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (IW'(j) == slot_i) begin
          valid_q[j] <= 1'b1;
          rank_q[j]  <= '0;
        end else if (valid_q[j] && (!upd_i.hit || (rank_q[j] < bound_i))) begin
          rank_q[j] <= rank_q[j] + RW'(1);
        end
      end
    end
  end

  // Read the frame under scan
  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];
  assign valid_o    = valid_q;

endmodule

FILE: rtl/lrupr_scan.sv
// Shared page comparator and capture registers for the frame walk.
`timescale 1ns / 1ps

module lrupr_scan #(
  parameter int unsigned PW = 16,
  parameter int unsigned IW = 4,
  parameter int unsigned RW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lrupr_pkg::scan_ctl_t  ctl_i,
  input  logic [IW-1:0]         idx_i,
  input  logic [PW-1:0]         ram_page_i,
  input  logic                  lane_valid_i,
  input  logic [RW-1:0]         lane_rank_i,
  input  logic [PW-1:0]         page_i,
  input  logic [RW-1:0]         oldest_rank_i,
  output lrupr_pkg::scan_res_t  res_o,
  output logic [IW-1:0]         found_idx_o,
  output logic [RW-1:0]         found_rank_o,
  output logic [IW-1:0]         free_idx_o,
  output logic [IW-1:0]         evict_idx_o,
  output logic [PW-1:0]         evict_page_o
);

  lrupr_pkg::scan_res_t res_q;
  logic [IW-1:0] found_idx_q, free_idx_q, evict_idx_q;
  logic [RW-1:0] found_rank_q;
  logic [PW-1:0] evict_page_q;
  logic          match;
  logic          oldest;

  // One compare per cycle against the frame being checked
  assign match  = lane_valid_i && (ram_page_i == page_i);
  assign oldest = lane_valid_i && (lane_rank_i == oldest_rank_i);

  // Control flags: clear on start, set as frames are checked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (ctl_i.start) begin
      res_q <= '0;
    end else if (ctl_i.check) begin
      if (match) begin
        res_q.found <= 1'b1;
      end
      if (!lane_valid_i) begin
        res_q.free_v <= 1'b1;
      end
    end
  end

  // Capture the hit frame, the lowest free frame and the oldest frame
  always_ff @(posedge clk_i) begin
    if (ctl_i.check) begin
      if (match) begin
        found_idx_q  <= idx_i;
        found_rank_q <= lane_rank_i;
      end
      if (!lane_valid_i && !res_q.free_v) begin
        free_idx_q <= idx_i;
      end
      if (oldest) begin
        evict_idx_q  <= idx_i;
        evict_page_q <= ram_page_i;
      end
    end
  end

  assign res_o        = res_q;
  assign found_idx_o  = found_idx_q;
  assign found_rank_o = found_rank_q;
  assign free_idx_o   = free_idx_q;
  assign evict_idx_o  = evict_idx_q;
  assign evict_page_o = evict_page_q;

endmodule

FILE: rtl/lru_page_replacement.sv
// Fully associative page-frame store with least-recently-used replacement.
//
// Usage: each input transaction on in_valid_i/in_ready_o carries one
// referenced page number. The block answers with one result transaction on
// out_valid_o/out_ready_i: hit flag, evicted page (zero when none) and the
// saturating hit and miss totals after this access.
// Access flow: the page RAM is walked one frame per cycle through its single
// read port and one comparator, then an update step updates ranks, the RAM
// and the counters. in_ready_o is high only when no access is in flight, so
// a new access is accepted only after the last one leaves its update step.
// The result sits in an output register; the next access is accepted while
// it waits. If the receiver stalls, a finished access holds in its update
// cycle until the output register frees, so nothing is lost.
// The frames_in_use register is written on cfg_valid_i/cfg_ready_o, always
// ready; values of 0 act as 1 and values above MAX_FRAMES as MAX_FRAMES.
// Reset clears all valid bits, ranks, the resident count and the counters
// at once; no clearing pass is needed. Page RAM contents are not reset.
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lrupr_pkg::PAGE_W-1:0]       page_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic                               evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]       evicted_page_o,
  output logic [lrupr_pkg::COUNT_W-1:0]      hit_count_o,
  output logic [lrupr_pkg::COUNT_W-1:0]      miss_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]        frames_in_use_i
);

  localparam int unsigned PW = (PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS
                                                              : lrupr_pkg::PAGE_W;
  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned RW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CNT_W = lrupr_pkg::COUNT_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          chk_q;
  logic [IW-1:0] chk_idx_q;
  logic [PW-1:0] page_q;
  logic [CW-1:0] rc_q;
  logic [lrupr_pkg::CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] hit_total_q, miss_total_q, hit_total_d, miss_total_d;

  logic                 out_valid_q;
  logic                 out_hit_q, out_ev_valid_q;
  logic [PW-1:0]        out_ev_page_q;
  logic [CNT_W-1:0]     out_hit_cnt_q, out_miss_cnt_q;

  logic [31:0]          limit;
  logic                 evict;
  logic                 finish;
  logic [IW-1:0]        slot;
  logic [PW-1:0]        ram_rdata;
  logic                 lane_valid;
  logic [RW-1:0]        lane_rank;
  logic [MAX_FRAMES-1:0] valid_vec;

  lrupr_pkg::scan_ctl_t scan_ctl;
  lrupr_pkg::scan_res_t scan_res;
  lrupr_pkg::lane_upd_t lane_upd;
  logic [IW-1:0] found_idx, free_idx, evict_idx;
  logic [RW-1:0] found_rank;
  logic [PW-1:0] evict_page;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lrupr_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= frames_in_use_i;
    end
  end

  // Clamp the frame limit and decide between eviction and fill
  always_comb begin
    limit = 32'(cfg_q);
    if (limit == 32'd0) begin
      limit = 32'd1;
    end else if (limit > 32'(MAX_FRAMES)) begin
      limit = 32'(MAX_FRAMES);
    end
  end
  assign evict = 32'(rc_q) >= limit;

  // Update step completes when the output register can take the result
  assign finish = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(MAX_FRAMES - 1)) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= (state_q == ST_SCAN);
    end
  end

  // Hold the page and track which frame the RAM data belongs to
  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q;
    if (in_valid_i && in_ready_o) begin
      page_q <= page_number_i[PW-1:0];
    end
  end

  // Page RAM: walked during the scan, written in the update step on a miss
  lrupr_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (finish && !scan_res.found),
    .waddr_i (slot),
    .wdata_i (page_q),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // Scan control
  assign scan_ctl.start = in_valid_i && in_ready_o;
  assign scan_ctl.check = chk_q;

  lrupr_scan #(
    .PW (PW),
    .IW (IW),
    .RW (RW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (scan_ctl),
    .idx_i         (chk_idx_q),
    .ram_page_i    (ram_rdata),
    .lane_valid_i  (lane_valid),
    .lane_rank_i   (lane_rank),
    .page_i        (page_q),
    .oldest_rank_i (RW'(rc_q - CW'(1))),
    .res_o         (scan_res),
    .found_idx_o   (found_idx),
    .found_rank_o  (found_rank),
    .free_idx_o    (free_idx),
    .evict_idx_o   (evict_idx),
    .evict_page_o  (evict_page)
  );

  // Pick the frame that becomes most recent
  always_comb begin
    if (scan_res.found) begin
      slot = found_idx;
    end else if (evict) begin
      slot = evict_idx;
    end else begin
      slot = free_idx;
    end
  end

  assign lane_upd.en  = finish;
  assign lane_upd.hit = scan_res.found;

  lrupr_lanes #(
    .MAX_FRAMES (MAX_FRAMES),
    .IW         (IW),
    .RW         (RW)
  ) u_lanes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (lane_upd),
    .slot_i     (slot),
    .bound_i    (found_rank),
    .rd_idx_i   (chk_idx_q),
    .rd_valid_o (lane_valid),
    .rd_rank_o  (lane_rank),
    .valid_o    (valid_vec)
  );

  // Saturating counters
  always_comb begin
    hit_total_d  = hit_total_q;
    miss_total_d = miss_total_q;
    if (scan_res.found) begin
      if (hit_total_q != '1) begin
        hit_total_d = hit_total_q + CNT_W'(1);
      end
    end else if (miss_total_q != '1) begin
      miss_total_d = miss_total_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_total_q  <= '0;
      miss_total_q <= '0;
      rc_q         <= '0;
    end else if (finish) begin
      hit_total_q  <= hit_total_d;
      miss_total_q <= miss_total_d;
      if (!scan_res.found && !evict) begin
        rc_q <= rc_q + CW'(1);
      end
    end
  end

  // Output register: load on finish, drop once the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_hit_q      <= scan_res.found;
      out_ev_valid_q <= !scan_res.found && evict;
      out_ev_page_q  <= (!scan_res.found && evict) ? evict_page : '0;
      out_hit_cnt_q  <= hit_total_d;
      out_miss_cnt_q <= miss_total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = lrupr_pkg::PAGE_W'(out_ev_page_q);
  assign hit_count_o     = out_hit_cnt_q;
  assign miss_count_o    = out_miss_cnt_q;

  // Resident count always matches the number of valid frames
  a_rc_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(valid_vec)) == 32'(rc_q))
    else $error("resident count does not match valid frames");

  // A fill without eviction always finds a free frame
  a_fill_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !scan_res.found && !evict) |-> scan_res.free_v)
    else $error("fill with no free frame");

  // A new result only appears after an update step
  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD))
    else $error("result without update step");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (!out_hit_q || !out_ev_valid_q))
    else $error("hit reported with eviction");

endmodule

FILE: dv/lru_page_replacement_test.sv
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 1ps

module lru_page_replacement_test;

  localparam int FRAMES      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 55;

  typedef struct packed {
    logic                          hit;
    logic                          evicted_valid;
    logic [lrupr_pkg::PAGE_W-1:0]  evicted_page;
    logic [lrupr_pkg::COUNT_W-1:0] hit_count;
    logic [lrupr_pkg::COUNT_W-1:0] miss_count;
  } access_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [lrupr_pkg::PAGE_W-1:0]  page_number_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          hit_o;
  logic                          evicted_valid_o;
  logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_o;
  logic [lrupr_pkg::COUNT_W-1:0] hit_count_o;
  logic [lrupr_pkg::COUNT_W-1:0] miss_count_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use_i = '0;

  // Page references waiting to be driven and results still owed by the block
  logic [lrupr_pkg::PAGE_W-1:0] page_queue[$];
  access_result_t               owed_results[$];

  // Shadow copy of the frame store
  logic [lrupr_pkg::PAGE_W-1:0]  shadow_page[FRAMES];
  logic                          shadow_valid[FRAMES];
  int                            shadow_rank[FRAMES];
  int                            shadow_residents = 0;
  logic [lrupr_pkg::COUNT_W-1:0] shadow_hits = '0;
  logic [lrupr_pkg::COUNT_W-1:0] shadow_misses = '0;
  logic [lrupr_pkg::CFG_W-1:0]   shadow_frames_in_use = lrupr_pkg::CFG_RESET;

  // Handshake flags seen at the last rising edge
  logic page_taken = 1'b0;
  logic result_taken = 1'b0;
  logic cfg_taken = 1'b0;

  int page_idle_max = 3;
  int result_stall_max = 3;
  int page_gap = 0;
  int result_stall = 0;
  int pages_queued = 0;
  int pages_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;

  lru_page_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .hit_count_o     (hit_count_o),
    .miss_count_o    (miss_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .frames_in_use_i (frames_in_use_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Age every resident frame younger than the bound
  function automatic void age_frames(input int bound);
    for (int i = 0; i < FRAMES; i++) begin
      if (shadow_valid[i] && shadow_rank[i] < bound) shadow_rank[i]++;
    end
  endfunction

  // Apply one page reference to the shadow store and return the expected result
  function automatic access_result_t reference_page(
      input logic [lrupr_pkg::PAGE_W-1:0] page);
    access_result_t res;
    int slot;
    int oldest;
    int cap;
    res = '0;
    slot = -1;
    oldest = 0;
    cap = (shadow_frames_in_use == 0) ? 1 :
          (shadow_frames_in_use > FRAMES) ? FRAMES : int'(shadow_frames_in_use);
    for (int i = 0; i < FRAMES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_page[i] == page) slot = i;
    end
    if (slot >= 0) begin
      // Hit: promote to most recent
      res.hit = 1'b1;
      age_frames(shadow_rank[slot]);
      shadow_rank[slot] = 0;
      if (shadow_hits != '1) shadow_hits++;
    end else begin
      if (shadow_residents >= cap) begin
        // Full: evict the oldest frame
        for (int i = 0; i < FRAMES; i++) begin
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > oldest)) begin
            slot = i;
            oldest = shadow_rank[i];
          end
        end
        if (slot >= 0) begin
          res.evicted_valid = 1'b1;
          res.evicted_page = shadow_page[slot];
          shadow_valid[slot] = 1'b0;
          age_frames(oldest);
        end
      end else begin
        // Room left: take the lowest free frame
        for (int i = 0; i < FRAMES; i++) begin
          if (slot < 0 && !shadow_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          age_frames(FRAMES + 1);
          shadow_residents++;
        end
      end
      if (slot >= 0) begin
        shadow_valid[slot] = 1'b1;
        shadow_page[slot] = page;
        shadow_rank[slot] = 0;
      end
      if (shadow_misses != '1) shadow_misses++;
    end
    res.hit_count = shadow_hits;
    res.miss_count = shadow_misses;
    return res;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Drive page references; count the gap only while the block is ready
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !page_taken)) begin
      if (page_taken) page_gap = $urandom_range(0, page_idle_max);
      if (page_gap > 0) begin
        if (in_ready_o) page_gap--;
        in_valid_i <= 1'b0;
      end else if (page_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        page_number_i <= page_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Hold off each result for its drawn stall once it shows up
  always @(negedge clk_i) begin
    if (result_taken) result_stall = $urandom_range(0, result_stall_max);
    if (out_valid_o && result_stall > 0) result_stall--;
    out_ready_i <= (result_stall == 0);
  end

  // Record transactions, predict on acceptance and check results
  always @(posedge clk_i) begin
    access_result_t want;
    cycle_count++;
    page_taken <= rst_ni && in_valid_i && in_ready_o;
    result_taken <= rst_ni && out_valid_o && out_ready_i;
    cfg_taken <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) shadow_frames_in_use = frames_in_use_i;
      if (in_valid_i && in_ready_o) begin
        owed_results.insert(owed_results.size(), reference_page(page_number_i));
        pages_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual hit %0b evict %0b/%0h",
                   $time, hit_o, evicted_valid_o, evicted_page_o);
        end else begin
          want = owed_results.pop_front();
          compare_field("hit", want.hit, hit_o);
          compare_field("evicted_valid", want.evicted_valid, evicted_valid_o);
          compare_field("evicted_page", want.evicted_page, evicted_page_o);
          compare_field("hit_count", want.hit_count, hit_count_o);
          compare_field("miss_count", want.miss_count, miss_count_o);
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_page(input logic [lrupr_pkg::PAGE_W-1:0] page);
    page_queue.insert(page_queue.size(), page);
    pages_queued++;
  endtask

  // Wait until every queued reference is accepted and answered
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pages_accepted != pages_queued || owed_results.size() != 0);
  endtask

  task automatic write_frames_in_use(input logic [lrupr_pkg::CFG_W-1:0] value);
    frames_in_use_i <= value;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [lrupr_pkg::CFG_W-1:0]  phase_limits[PHASES];
    logic [lrupr_pkg::PAGE_W-1:0] pool[$];
    int cap;
    int span;
    for (int i = 0; i < FRAMES; i++) begin
      shadow_page[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    phase_limits = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2, 5'd8, 5'd0, 5'd0, 5'd0};
    for (int p = 7; p < PHASES; p++) begin
      phase_limits[p] = lrupr_pkg::CFG_W'($urandom_range(0, 31));
    end

    // Hold reset, release on a falling edge
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, hits, fill all frames, then evict
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'hAAAA);
    queue_page(16'h5555);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    for (int i = 0; i < 12; i++) queue_page(16'h0001 << i);
    queue_page(16'h1234);
    queue_page(16'hAAAA);
    wait_idle();

    // Random phases; the first drops the limit below the resident count
    for (int p = 0; p < PHASES; p++) begin
      page_idle_max = (p % 3 == 1) ? 0 : 3;
      result_stall_max = (p % 3 == 1 || p == 2) ? 0 : 3;
      write_frames_in_use(phase_limits[p]);
      cap = (phase_limits[p] == 0) ? 1 :
            (phase_limits[p] > FRAMES) ? FRAMES : int'(phase_limits[p]);
      span = cap + $urandom_range(0, 4);
      pool.delete();
      for (int i = 0; i < span; i++) pool.insert(pool.size(), lrupr_pkg::PAGE_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) queue_page(pool[$urandom_range(0, span - 1)]);
        else queue_page(lrupr_pkg::PAGE_W'($urandom));
      end
      wait_idle();
    end

    // Let any stray result show up before deciding
    repeat (3 * FRAMES) @(negedge clk_i);
    if (error_count == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lrupr_pkg.sv
rtl/lrupr_ram.sv
rtl/lrupr_lanes.sv
rtl/lrupr_scan.sv
rtl/lru_page_replacement.sv
dv/lru_page_replacement_test.sv
